// File: sv/ilp_pkg.sv
`timescale 1ns / 1ps

package ilp_pkg;

    // result bus: value, radix code, error code, u flag, l flag, ll flag
    localparam int VALUE_W = 64;
    localparam int OUT_W   = 72;

    // classified-item queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [1:0] RC_BIN = 2'd0;
    localparam logic [1:0] RC_OCT = 2'd1;
    localparam logic [1:0] RC_DEC = 2'd2;
    localparam logic [1:0] RC_HEX = 2'd3;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_DIGITS = 3'd1;
    localparam logic [2:0] ERR_PREFIX    = 3'd2;
    localparam logic [2:0] ERR_CHAR      = 3'd3;
    localparam logic [2:0] ERR_RANGE     = 3'd4;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd5;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_O     = 8'h6f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CASE_OFS = 8'h20;
    localparam logic [7:0] HEX_OFS  = 8'd10;

    // one character after classification
    typedef struct packed {
        logic       is_end;
        logic       is_u;
        logic       is_l;
        logic       is_zero;
        logic       is_x;
        logic       is_o;
        logic       is_b;
        logic       is_sep;
        logic       dig_ok;
        logic [3:0] dig;
    } t_cls;

endpackage

// File: sv/ilp_front.sv
`timescale 1ns / 1ps

module ilp_front import ilp_pkg::*; (
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] character
    input  logic       s_axis_tlast,   // end marker
    input  logic       i_full,
    output logic       o_push,
    output t_cls       o_item
);

    logic [7:0] w_lc;
    logic       w_is_dec;
    logic       w_is_hex;

    always_comb begin
        w_lc = s_axis_tdata;
        if (s_axis_tdata >= CH_UP_A && s_axis_tdata <= CH_UP_Z) begin
            w_lc = s_axis_tdata + CASE_OFS;
        end
        w_is_dec = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
        w_is_hex = (w_lc >= CH_A) && (w_lc <= CH_F);

        o_item.is_end  = s_axis_tlast;
        o_item.is_u    = (w_lc == CH_U);
        o_item.is_l    = (w_lc == CH_L);
        o_item.is_zero = (s_axis_tdata == CH_ZERO);
        o_item.is_x    = (w_lc == CH_X);
        o_item.is_o    = (w_lc == CH_O);
        o_item.is_b    = (w_lc == CH_B);
        o_item.is_sep  = (s_axis_tdata == CH_APOS) || (s_axis_tdata == CH_UNDER);
        o_item.dig_ok  = w_is_dec || w_is_hex;
        if (w_is_dec) begin
            o_item.dig = 4'(s_axis_tdata - CH_ZERO);
        end else begin
            o_item.dig = 4'((w_lc - CH_A) + HEX_OFS);
        end
    end

    assign s_axis_tready = !i_full;
    assign o_push        = s_axis_tvalid && !i_full;

endmodule

// File: sv/ilp_queue.sv
`timescale 1ns / 1ps

module ilp_queue import ilp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_item,
    output logic o_full,
    output logic o_valid,
    output t_cls o_item,
    input  logic i_pop
);

    t_cls           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

endmodule

// File: sv/ilp_back.sv
`timescale 1ns / 1ps

module ilp_back import ilp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_cls             i_q_item,
    output logic             o_q_pop,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [63:0] value, [65:64] radix_code, [68:66] error_code,
    // [69] has_unsigned, [70] has_long, [71] has_long_long
    output logic [OUT_W-1:0] m_axis_tdata
);

    typedef enum logic [1:0] {
        PH_START,
        PH_ZERO,
        PH_DIGITS
    } t_phase;

    t_phase             r_phase,  n_phase;
    logic [VALUE_W-1:0] r_acc,    n_acc;
    logic [1:0]         r_radix,  n_radix;
    logic [2:0]         r_err,    n_err;
    logic               r_run_u,  n_run_u;
    logic               r_run_l,  n_run_l;
    logic               r_run_ll, n_run_ll;
    logic               r_prev_l, n_prev_l;
    logic               r_run_second, n_run_second;
    logic               r_out_valid,  n_out_valid;
    logic [OUT_W-1:0]   r_out_data,   n_out_data;

    logic               w_pop;
    logic [VALUE_W+3:0] w_prod;
    logic [VALUE_W+3:0] w_sum;
    logic               w_range_bad;
    logic [VALUE_W-1:0] w_val;
    logic [1:0]         w_rc;
    logic [2:0]         w_err;

    // accumulator times radix by shifts and adds, four spare bits for overflow
    always_comb begin
        case (r_radix)
            RC_BIN:  w_prod = {3'b000, r_acc, 1'b0};
            RC_OCT:  w_prod = {1'b0, r_acc, 3'b000};
            RC_DEC:  w_prod = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0};
            RC_HEX:  w_prod = {r_acc, 4'b0000};
            default: w_prod = '0;
        endcase
        w_sum = w_prod + (VALUE_W+4)'(i_q_item.dig);
        case (r_radix)
            RC_BIN:  w_range_bad = (i_q_item.dig >= 4'd2);
            RC_OCT:  w_range_bad = (i_q_item.dig >= 4'd8);
            RC_DEC:  w_range_bad = (i_q_item.dig >= 4'd10);
            RC_HEX:  w_range_bad = 1'b0;
            default: w_range_bad = 1'b0;
        endcase
    end

    assign w_pop = i_q_valid && (!i_q_item.is_end || !r_out_valid || m_axis_tready);

    always_comb begin
        n_phase      = r_phase;
        n_acc        = r_acc;
        n_radix      = r_radix;
        n_err        = r_err;
        n_run_u      = r_run_u;
        n_run_l      = r_run_l;
        n_run_ll     = r_run_ll;
        n_prev_l     = r_prev_l;
        n_run_second = r_run_second;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;

        w_val = r_acc;
        w_rc  = r_radix;
        w_err = r_err;
        if (r_phase == PH_START) begin
            w_err = ERR_NO_DIGITS;
            w_rc  = RC_DEC;
        end else if (r_phase == PH_ZERO) begin
            w_rc  = RC_OCT;
            w_val = '0;
        end
        if (w_err != ERR_NONE) begin
            w_val = '0;
        end

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (w_pop) begin
            if (i_q_item.is_end) begin
                n_out_valid  = 1'b1;
                n_out_data   = {r_run_ll, r_run_l && !r_run_ll, r_run_u, w_err, w_rc, w_val};
                n_phase      = PH_START;
                n_acc        = '0;
                n_radix      = RC_DEC;
                n_err        = ERR_NONE;
                n_run_u      = 1'b0;
                n_run_l      = 1'b0;
                n_run_ll     = 1'b0;
                n_prev_l     = 1'b0;
                n_run_second = 1'b0;
            end else if (i_q_item.is_u || i_q_item.is_l) begin
                // held pending until we know whether it is the trailing suffix
                if (!r_run_u && !r_run_l) begin
                    n_run_second = (r_phase == PH_ZERO);
                end
                if (i_q_item.is_u) begin
                    n_run_u  = 1'b1;
                    n_prev_l = 1'b0;
                end else begin
                    if (r_prev_l) begin
                        n_run_ll = 1'b1;
                    end
                    n_run_l  = 1'b1;
                    n_prev_l = 1'b1;
                end
            end else if (r_run_u || r_run_l) begin
                // interior u/l run: its first letter is the error, the
                // current character can no longer change anything
                if (r_err == ERR_NONE) begin
                    n_err = r_run_second ? ERR_PREFIX : ERR_CHAR;
                end
                if (!r_run_second && r_phase == PH_START) begin
                    n_radix = RC_DEC;
                end
                n_phase      = PH_DIGITS;
                n_run_u      = 1'b0;
                n_run_l      = 1'b0;
                n_run_ll     = 1'b0;
                n_prev_l     = 1'b0;
                n_run_second = 1'b0;
            end else if (r_phase == PH_START && i_q_item.is_zero) begin
                n_phase = PH_ZERO;
            end else if (r_phase == PH_ZERO) begin
                if (i_q_item.is_x) begin
                    n_radix = RC_HEX;
                end else if (i_q_item.is_o) begin
                    n_radix = RC_OCT;
                end else if (i_q_item.is_b) begin
                    n_radix = RC_BIN;
                end else if (r_err == ERR_NONE) begin
                    n_err = ERR_PREFIX;
                end
                n_phase = PH_DIGITS;
            end else begin
                if (r_phase == PH_START) begin
                    n_radix = RC_DEC;
                end
                n_phase = PH_DIGITS;
                if (r_err == ERR_NONE && !i_q_item.is_sep) begin
                    if (!i_q_item.dig_ok) begin
                        n_err = ERR_CHAR;
                    end else if (w_range_bad) begin
                        n_err = ERR_RANGE;
                    end else if (w_sum[VALUE_W+3:VALUE_W] != '0) begin
                        n_err = ERR_OVERFLOW;
                    end else begin
                        n_acc = w_sum[VALUE_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_acc        <= '0;
            r_radix      <= RC_DEC;
            r_err        <= ERR_NONE;
            r_run_u      <= 1'b0;
            r_run_l      <= 1'b0;
            r_run_ll     <= 1'b0;
            r_prev_l     <= 1'b0;
            r_run_second <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_acc        <= n_acc;
            r_radix      <= n_radix;
            r_err        <= n_err;
            r_run_u      <= n_run_u;
            r_run_l      <= n_run_l;
            r_run_ll     <= n_run_ll;
            r_prev_l     <= n_prev_l;
            r_run_second <= n_run_second;
            r_out_valid  <= n_out_valid;
        end
        r_out_data <= n_out_data;
    end

    assign o_q_pop       = w_pop;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && i_q_item.is_end) |=>
            (r_phase == PH_START && r_acc == '0 && r_err == ERR_NONE && !r_run_u && !r_run_l))
        else $error("state not cleared after end transaction");

    a_start_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_START) |-> (r_err == ERR_NONE && r_radix == RC_DEC && r_acc == '0))
        else $error("error or value recorded before any character");

    a_error_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[VALUE_W+4:VALUE_W+2] != ERR_NONE) |->
            (r_out_data[VALUE_W-1:0] == '0))
        else $error("nonzero value reported with an error");

    a_long_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[OUT_W-1] && r_out_data[OUT_W-2]))
        else $error("long and long long both set");

    a_no_pop_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && i_q_item.is_end) |=> r_out_valid)
        else $error("end transaction did not produce a result");

endmodule

// File: sv/integer_literal_parser.sv
`timescale 1ns / 1ps

// Parses a C-style integer literal sent one character per transaction on
// s_axis, closed by a transaction with s_axis_tlast high (its tdata is
// ignored); each closing transaction yields exactly one result on m_axis.
// The block takes one transaction per cycle while its queue is not full:
// the front end classifies each character, a four-entry queue holds
// classified items, and the back end updates the 64-bit value with one
// shift-and-add multiply by the radix plus exact overflow check per cycle.
// A closing transaction passes through the queue and then the result
// register, and the result register lets the next literal keep flowing
// while it waits for m_axis_tready.
module integer_literal_parser import ilp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] character
    input  logic             s_axis_tlast,   // end marker
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [63:0] value, [65:64] radix_code, [68:66] error_code,
    // [69] has_unsigned, [70] has_long, [71] has_long_long
    output logic [OUT_W-1:0] m_axis_tdata
);

    logic w_full;
    logic w_push;
    t_cls w_front_item;
    logic w_q_valid;
    t_cls w_q_item;
    logic w_q_pop;

    ilp_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_item        (w_front_item)
    );

    ilp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    ilp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_q_pop       (w_q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
